// ===== rtl/cpp_pkg.sv =====
// Package with the shared constants, types and decode functions of the command packet parser.
`default_nettype none

package cpp_pkg;

  localparam logic [7:0] CH_HEADER = 8'h24;  // '$'
  localparam logic [7:0] CH_END    = 8'h23;  // '#'

  localparam int unsigned CountWidth = 4;
  localparam logic [CountWidth-1:0] NameLen   = CountWidth'(3);
  localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};

  typedef enum logic [2:0] {
    CMD_GOO = 3'd0,
    CMD_END = 3'd1,
    CMD_SPD = 3'd2,
    CMD_ALT = 3'd3,
    CMD_MAN = 3'd4,
    CMD_LED = 3'd5,
    CMD_UNK = 3'd7
  } cmd_e;

  typedef enum logic {
    KIND_CMD = 1'b0,
    KIND_ERR = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  command_code;
    logic [15:0] command_value;
    logic [7:0]  packet_count;
  } rslt_t;

  // Maps the three command letters to a command code.
  function automatic cmd_e cmd_decode(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2);
    cmd_e k;
    k = CMD_UNK;
    if      (c0 == "G" && c1 == "O" && c2 == "O") k = CMD_GOO;
    else if (c0 == "E" && c1 == "N" && c2 == "D") k = CMD_END;
    else if (c0 == "S" && c1 == "P" && c2 == "D") k = CMD_SPD;
    else if (c0 == "A" && c1 == "L" && c2 == "T") k = CMD_ALT;
    else if (c0 == "M" && c1 == "A" && c2 == "N") k = CMD_MAN;
    else if (c0 == "L" && c1 == "E" && c2 == "D") k = CMD_LED;
    return k;
  endfunction

  // Number of hex digits that follow each command.
  function automatic logic [CountWidth-1:0] cmd_digits(input cmd_e k);
    logic [CountWidth-1:0] n;
    case (k)
      CMD_GOO: n = CountWidth'(4);
      CMD_SPD: n = CountWidth'(4);
      CMD_ALT: n = CountWidth'(4);
      CMD_MAN: n = CountWidth'(2);
      CMD_LED: n = CountWidth'(2);
      default: n = '0;
    endcase
    return n;
  endfunction

  // True when the byte is a hex digit; the nibble is zero otherwise.
  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= "0" && c <= "9")      n = 4'(c - "0");
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cpp_if.sv =====
// Handshake interfaces for the received byte channel and the result channel.
`default_nettype none

interface cpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  command_code;
  logic [15:0] command_value;
  logic [7:0]  packet_count;

  modport source (output valid, output kind, output command_code, output command_value,
                  output packet_count, input ready);
  modport sink   (input valid, input kind, input command_code, input command_value,
                  input packet_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/command_packet_parser.sv =====
// Top level of the command packet parser: frame state, decode and the result buffer.
//
// Usage: bytes of a serial stream arrive on rx_i, one per transfer. The block
// looks for frames made of '$', a three-letter command (GOO, END, SPD, ALT, MAN,
// LED), the hex digits of its value (4, 0, 4, 4, 2 and 2 digits) and '#'.
// Each '#' inside a frame, and each '$' that interrupts a frame, gives one
// transfer on res_o: either a command with its decoded value and the running
// count of good packets, or a format error. Other bytes give no result.
// A result is registered and reaches res_o once each result ahead is taken.
// One byte per cycle unless two results wait; the frame state is updated by
// short logic between the byte handshake and a two-entry result buffer.
// A byte is taken whenever the second buffer entry is free, so a result may sit
// unclaimed while further bytes stream in; only when two results wait does
// rx_i.ready drop, and it comes back the cycle after the receiver takes one.
// Reset (rst_ni low, asynchronous) closes any frame, empties the buffer and
// clears the packet count. Results are never dropped or repeated.
`default_nettype none

module command_packet_parser
  import cpp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cpp_byte_if.sink      rx_i,
  cpp_result_if.source  res_o
);

  // Frame state.
  logic                  in_body_q, in_body_d;
  logic [CountWidth-1:0] count_q, count_d;
  cmd_e                  kind_q, kind_d;
  logic [15:0]           acc_q, acc_d;
  logic                  derr_q, derr_d;
  logic [7:0]            vcount_q, vcount_d;
  // The first two command letters; the third is decoded as it arrives.
  logic [7:0]            char0_q, char0_d, char1_q, char1_d;

  // Result buffer: a head entry that drives res_o and a second entry behind it.
  logic  head_vld_q, head_vld_d, skid_vld_q, skid_vld_d;
  rslt_t head_q, head_d, skid_q, skid_d;

  logic                  take;
  logic                  pop;
  logic                  emit;
  rslt_t                 rslt;
  logic [7:0]            b;
  logic                  is_hdr, is_end;
  logic [CountWidth-1:0] body_len;
  logic                  bad;

  assign b      = rx_i.rx_byte;
  assign is_hdr = (b == CH_HEADER);
  assign is_end = (b == CH_END);
  assign take   = rx_i.valid && rx_i.ready;
  assign pop    = head_vld_q && res_o.ready;

  assign body_len = NameLen + cmd_digits(kind_q);
  assign bad = (count_q < NameLen) || (kind_q == CMD_UNK) || derr_q || (count_q != body_len);

  // Frame tracking and result formation for the byte on the input.
  always_comb begin
    in_body_d = in_body_q;
    count_d   = count_q;
    kind_d    = kind_q;
    acc_d     = acc_q;
    derr_d    = derr_q;
    vcount_d  = vcount_q;
    char0_d   = char0_q;
    char1_d   = char1_q;
    emit      = 1'b0;
    rslt      = '{kind: KIND_ERR, command_code: 3'd0, command_value: 16'd0,
                  packet_count: vcount_q};

    if (!in_body_q) begin
      // Outside a frame only a header byte matters.
      if (is_hdr) begin
        in_body_d = 1'b1;
        count_d   = '0;
        kind_d    = CMD_GOO;
        acc_d     = '0;
        derr_d    = 1'b0;
      end
    end else if (is_end) begin
      in_body_d = 1'b0;
      emit      = 1'b1;
      if (!bad) begin
        vcount_d = vcount_q + 8'd1;
        rslt     = '{kind: KIND_CMD, command_code: kind_q, command_value: acc_q,
                     packet_count: vcount_q + 8'd1};
      end
    end else if (is_hdr) begin
      // A header inside a body reports an error and starts the body again.
      emit    = 1'b1;
      count_d = '0;
      kind_d  = CMD_GOO;
      acc_d   = '0;
      derr_d  = 1'b0;
    end else begin
      if (count_q < NameLen) begin
        if (count_q == CountWidth'(0)) char0_d = b;
        if (count_q == CountWidth'(1)) char1_d = b;
        if (count_q == CountWidth'(2)) kind_d = cmd_decode(char0_q, char1_q, b);
      end else if (count_q < body_len) begin
        if (!hex_ok(b)) derr_d = 1'b1;
        acc_d = {acc_q[11:0], hex_nibble(b)};
      end
      if (count_q != CountMax) count_d = count_q + CountWidth'(1);
    end
  end

  // Two-entry result buffer; a byte is taken whenever the second entry is free.
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = take && emit;
        skid_d     = rslt;
      end else begin
        head_vld_d = take && emit;
        head_d     = rslt;
      end
    end else if (take && emit) begin
      if (head_vld_q) begin
        skid_vld_d = 1'b1;
        skid_d     = rslt;
      end else begin
        head_vld_d = 1'b1;
        head_d     = rslt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q  <= 1'b0;
      count_q    <= '0;
      kind_q     <= CMD_GOO;
      acc_q      <= '0;
      derr_q     <= 1'b0;
      vcount_q   <= '0;
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_body_q <= in_body_d;
        count_q   <= count_d;
        kind_q    <= kind_d;
        acc_q     <= acc_d;
        derr_q    <= derr_d;
        vcount_q  <= vcount_d;
      end
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Letters and buffered results are only read after they have been written.
  always_ff @(posedge clk_i) begin
    if (take) begin
      char0_q <= char0_d;
      char1_q <= char1_d;
    end
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign rx_i.ready          = !skid_vld_q;
  assign res_o.valid         = head_vld_q;
  assign res_o.kind          = head_q.kind;
  assign res_o.command_code  = head_q.command_code;
  assign res_o.command_value = head_q.command_value;
  assign res_o.packet_count  = head_q.packet_count;

endmodule

`default_nettype wire

// ===== rtl/cpp_checker.sv =====
// Port-level checks of the command packet parser and the bind that attaches them.
`default_nettype none

module cpp_checker
  import cpp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        kind_i,
  input wire logic [2:0]  command_code_i,
  input wire logic [15:0] command_value_i,
  input wire logic [7:0]  packet_count_i
);

  // A result that waits must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(kind_i) && $stable(command_code_i) &&
      $stable(command_value_i) && $stable(packet_count_i))
    else $error("result changed while stalled");

  // An error carries neither a command nor a value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_ERR |-> command_code_i == 3'd0 && command_value_i == 16'd0)
    else $error("error result with command fields");

  // A good packet names a known command.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_CMD |-> command_code_i <= CMD_LED)
    else $error("unknown command code on a good packet");

  // END has no value, and two-digit commands fit in a byte.
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_CMD &&
    (command_code_i == CMD_END || command_code_i == CMD_MAN || command_code_i == CMD_LED)
      |-> command_value_i[15:8] == 8'd0 &&
          (command_code_i != CMD_END || command_value_i == 16'd0))
    else $error("value wider than its command allows");

endmodule

bind command_packet_parser cpp_checker u_cpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .kind_i          (res_o.kind),
  .command_code_i  (res_o.command_code),
  .command_value_i (res_o.command_value),
  .packet_count_i  (res_o.packet_count)
);

`default_nettype wire

// ===== sim/tb_command_packet_parser.sv =====
// Self-checking testbench for the command packet parser: byte stimulus and a result scoreboard.
`timescale 1ns / 1ps

module tb_command_packet_parser;
  import cpp_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off below, so this is ample.
  localparam int unsigned HangLimit   = 2000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StreamBytes = 1550;

  // Golden model of the parser together with the queue of results it predicts.
  // take_byte() advances the frame state for every accepted byte and queues
  // the result that byte must produce; compare_result() pops the oldest one.
  class frame_checker;
    rslt_t       pending_results[$];
    int unsigned errors;

    logic        in_frame;
    logic [3:0]  body_len;
    logic [7:0]  name_chars[3];
    cmd_e        cmd;
    logic [15:0] value_acc;
    logic        bad_digit;
    logic [7:0]  good_packets;

    function new();
      errors       = 0;
      in_frame     = 1'b0;
      good_packets = '0;
      foreach (name_chars[i]) name_chars[i] = '0;
      clear_body();
    endfunction

    static function bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
      nib = '0;
      if (c >= "0" && c <= "9") nib = 4'(c - "0");
      else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
      else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void clear_body();
      body_len  = '0;
      value_acc = '0;
      bad_digit = 1'b0;
      cmd       = CMD_GOO;
    endfunction

    function cmd_e lookup_command();
      case ({name_chars[0], name_chars[1], name_chars[2]})
        "GOO":   return CMD_GOO;
        "END":   return CMD_END;
        "SPD":   return CMD_SPD;
        "ALT":   return CMD_ALT;
        "MAN":   return CMD_MAN;
        "LED":   return CMD_LED;
        default: return CMD_UNK;
      endcase
    endfunction

    function int unsigned value_digits(input cmd_e k);
      case (k)
        CMD_GOO, CMD_SPD, CMD_ALT: return 4;
        CMD_MAN, CMD_LED:          return 2;
        default:                   return 0;
      endcase
    endfunction

    function void push_format_error();
      rslt_t r;
      r.kind          = KIND_ERR;
      r.command_code  = '0;
      r.command_value = '0;
      r.packet_count  = good_packets;
      pending_results.push_back(r);
    endfunction

    function void take_byte(input logic [7:0] b);
      rslt_t      r;
      logic [3:0] nib;
      if (!in_frame) begin
        // Outside a frame only a header byte matters.
        if (b == CH_HEADER) begin
          in_frame = 1'b1;
          clear_body();
        end
        return;
      end
      if (b == CH_END) begin
        in_frame = 1'b0;
        if (body_len < NameLen || cmd == CMD_UNK || bad_digit ||
            body_len != 3 + value_digits(cmd)) begin
          push_format_error();
        end else begin
          good_packets++;
          r.kind          = KIND_CMD;
          r.command_code  = cmd;
          r.command_value = value_acc;
          r.packet_count  = good_packets;
          pending_results.push_back(r);
        end
        return;
      end
      if (b == CH_HEADER) begin
        // A header inside a body reports an error and starts the body over.
        push_format_error();
        clear_body();
        return;
      end
      if (body_len < 3) begin
        name_chars[body_len[1:0]] = b;
        if (body_len == 2) cmd = lookup_command();
      end else if (body_len < 3 + value_digits(cmd)) begin
        if (!hex_digit(b, nib)) bad_digit = 1'b1;
        value_acc = {value_acc[11:0], nib};
      end
      // The body length sticks at its maximum on overlong bodies.
      if (body_len != CountMax) body_len++;
    endfunction

    function void compare_result(input rslt_t got);
      rslt_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d code %0d value %0h count %0d",
               got.kind, got.command_code, got.command_value, got.packet_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.command_code !== want.command_code) begin
        $error("command_code: expected %0d, got %0d", want.command_code, got.command_code);
        errors++;
      end
      if (got.command_value !== want.command_value) begin
        $error("command_value: expected %0h, got %0h", want.command_value, got.command_value);
        errors++;
      end
      if (got.packet_count !== want.packet_count) begin
        $error("packet_count: expected %0d, got %0d", want.packet_count, got.packet_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cpp_byte_if   rx_if();
  cpp_result_if res_if();

  command_packet_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .res_o  (res_if.source)
  );

  always #10 clk_i = ~clk_i;

  frame_checker sb = new();

  string       mnemonics[6]    = '{"GOO", "END", "SPD", "ALT", "MAN", "LED"};
  int unsigned digit_counts[6] = '{4, 0, 4, 4, 2, 2};
  string       hex_chars       = "0123456789abcdefABCDEF";

  int unsigned bytes_offered;  // frame bytes sent; stray noise bytes are not counted
  int unsigned results_taken;
  int unsigned quiet_cycles;
  bit          sender_idling;

  // Monitor: every transfer on either channel is observed here, at the clock
  // edge where it happens. Values read right after the edge are the ones the
  // block saw, since everything it drives is updated later in the time step.
  // The same process counts quiet cycles for the hang watchdog.
  always @(posedge clk_i) begin : monitor
    rslt_t seen;
    bit    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen.kind          = kind_e'(res_if.kind);
        seen.command_code  = res_if.command_code;
        seen.command_value = res_if.command_value;
        seen.packet_count  = res_if.packet_count;
        sb.compare_result(seen);
        results_taken++;
        moved = 1'b1;
      end
      if (rx_if.valid && rx_if.ready) begin
        sb.take_byte(rx_if.rx_byte);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles == HangLimit) begin
      $display("tb_command_packet_parser: done, errors");
      $finish;
    end
  end

  // Result receiver. It stalls about one cycle in five, except for a window
  // of results where it takes everything at once. Early in the run it holds
  // ready low for a long stretch so that the two-entry result buffer fills
  // up and the block has to back-pressure the byte stream.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_taken >= 40) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (results_taken >= 80 && results_taken < 130) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Offers one byte and waits until it has been transferred. Valid is left
  // high afterwards; the next call either keeps it up or drops it for a gap.
  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    while (sender_idling && $urandom_range(99) < 20) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    if (counted) bytes_offered++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic wait_for_results();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_hex();
    return hex_chars[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] random_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_HEADER || b == CH_END);
    return b;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    logic [3:0] nib;
    do b = random_body_byte(); while (frame_checker::hex_digit(b, nib));
    return b;
  endfunction

  // One frame of random shape. Most frames are well formed with random
  // values; the rest are stray noise, short names, unknown names, bodies cut
  // by a new header, overlong bodies, wrong digit counts and bad digits.
  task automatic send_random_frame();
    int unsigned pick, idx, ndig, n, bad_at, i;
    pick = $urandom_range(99);
    idx  = $urandom_range(5);
    ndig = digit_counts[idx];
    if (pick < 8) begin
      // Noise between frames. A stray header here opens a frame that the
      // next header then interrupts, which is also worth seeing.
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)), 1'b0);
      return;
    end
    send_byte(CH_HEADER);
    if (pick < 14) begin
      n = $urandom_range(2);
      for (i = 0; i < n; i++) send_byte(mnemonics[idx][i]);
      send_byte(CH_END);
      return;
    end
    if (pick < 20) begin
      repeat (3) send_byte(8'("A" + $urandom_range(25)));
      repeat ($urandom_range(4)) send_byte(random_hex());
      send_byte(CH_END);
      return;
    end
    if (pick < 26) begin
      repeat ($urandom_range(6, 1)) send_byte(random_body_byte());
      send_byte(CH_HEADER);
    end
    for (i = 0; i < 3; i++) send_byte(mnemonics[idx][i]);
    if (pick >= 26 && pick < 32) begin
      // Long enough for the body length to saturate.
      repeat ($urandom_range(20, 13)) send_byte(random_body_byte());
      send_byte(CH_END);
      return;
    end
    n = ndig;
    if (pick >= 32 && pick < 40) begin
      n = $urandom_range(6);
      if (n == ndig) n++;
    end
    bad_at = (pick >= 40 && pick < 46 && ndig > 0) ? $urandom_range(ndig - 1) : 99;
    for (i = 0; i < n; i++) send_byte(i == bad_at ? random_non_hex() : random_hex());
    send_byte(CH_END);
  endtask

  initial begin : stimulus
    int unsigned frames;
    frames        = 0;
    bytes_offered = 0;
    results_taken = 0;
    quiet_cycles  = 0;
    sender_idling = 1'b1;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: all-zero and all-one bytes and a lone end marker outside
    // a frame, every command with extreme and mixed-case values, an unknown
    // name, a short name, a header that cuts a body, a bad hex digit and one
    // digit too many.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_END, 1'b0);
    send_text("$GOOFFFF#$END#$SPD0000#$ALTaBcD#$MAN7f#$LED00#");
    send_text("$XYZ#$AB#$GO$LED1g#$MAN123#");

    // Random part. Partway through, the sender stops and lets the block
    // drain completely; later there is a long stretch without sender gaps.
    while (bytes_offered < StreamBytes) begin
      frames++;
      if (frames == 60) wait_for_results();
      sender_idling = !(bytes_offered >= 700 && bytes_offered < 1000);
      send_random_frame();
    end

    wait_for_results();
    // A final idle wait catches any result the block adds on its own.
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_command_packet_parser: done, clean");
    end else begin
      $display("tb_command_packet_parser: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cpp_pkg.sv
rtl/cpp_if.sv
rtl/command_packet_parser.sv
rtl/cpp_checker.sv
sim/tb_command_packet_parser.sv
